// ===== rtl/dtc_pkg.sv =====
// shared types, command codes and helper functions of the decision tree classifier
package dtc_pkg;

    // field widths of the command transaction
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 11;
    localparam int FIDX_W = 4;
    localparam int CIDX_W = 4;
    localparam int VAL_W  = 32;
    localparam int PROB_W = 17;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE_NODE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_PROB   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_FEATURE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY     = 2'd3;

    // one entry of the node table
    typedef struct packed {
        logic                    leaf;
        logic [FIDX_W-1:0]       feature;
        logic signed [VAL_W-1:0] threshold;
        logic [IDX_W-1:0]        left;
        logic [IDX_W-1:0]        right;
        logic [CIDX_W-1:0]       label;
    } node_t;

    // write request into the feature store
    typedef struct packed {
        logic                    en;
        logic [FIDX_W-1:0]       idx;
        logic signed [VAL_W-1:0] value;
    } feat_wr_t;

    // clamp a written probability to 0..one
    function automatic logic [PROB_W-1:0] sat_prob(input logic signed [VAL_W-1:0] v);
        logic [PROB_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > 32'sd65536) begin
            r = 17'd65536;
        end else begin
            r = v[PROB_W-1:0];
        end
        return r;
    endfunction

    // number of shifted compare-subtract steps that bring a child index below nodes
    function automatic int red_shifts(input int nodes);
        int s;
        s = 0;
        while ((nodes << s) <= ((1 << IDX_W) - 1)) begin
            s = s + 1;
        end
        return s;
    endfunction

endpackage

// ===== rtl/dtc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module dtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port, read data holds between reads
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/dtc_feat_store.sv =====
// feature value store with out-of-range slots reading as zero
module dtc_feat_store #(
    parameter int FEATURES = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dtc_pkg::feat_wr_t                   wr,
    input  logic [dtc_pkg::FIDX_W-1:0]          rd_idx,
    output logic signed [dtc_pkg::VAL_W-1:0]    rd_value
);

    logic signed [dtc_pkg::VAL_W-1:0] slot_reg [FEATURES];

    // slot writes, slots beyond the store are dropped
    always_ff @(posedge aclk) begin
        for (int i = 0; i < FEATURES; i++) begin
            if (!aresetn) begin
                slot_reg[i] <= '0;
            end else if (wr.en && (32'(wr.idx) == i)) begin
                slot_reg[i] <= wr.value;
            end
        end
    end

    // select the split feature, zero beyond the store
    always_comb begin
        rd_value = '0;
        for (int i = 0; i < FEATURES; i++) begin
            if (32'(rd_idx) == i) begin
                rd_value = slot_reg[i];
            end
        end
    end

endmodule

// ===== rtl/decision_tree_classify.sv =====
// decision tree classifier top level: command decode, tree walk sequencer and result stream
//
// Commands arrive one per s_ transaction and the input is not ready while one is in work.
// Node, probability and feature writes are made in the dispatch state. A classify walks the
// node table from node 0 with one node-ram read per cycle while no child index is being
// reduced; the node-ram read loop sets the walk and the probability-ram read port sets the
// result stream, one result per cycle while the receiver does not stall it. A child index
// at or beyond NODES is reduced by shifted compare-subtract steps. Results sit in an output
// register, so the next command is taken while the last result waits. The node and
// probability tables are not cleared at reset and must be written before they are read; the
// feature store resets to zero, and class_count resets to 3.
module decision_tree_classify #(
    parameter int NODES      = 2048,
    parameter int CLASSES    = 10,
    parameter int FEATURES   = 10,
    parameter int WALK_LIMIT = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata from bit 0: node_index[10:0], leaf_flag, feature_index[3:0], class_index[3:0],
    // value[31:0], left_child[10:0], right_child[10:0], zero pad
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_tuser,
    // tdata from bit 0: predicted_class[3:0], reported_class[3:0], probability[16:0],
    // zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output logic        m_tlast,
    // tuser: depth_error
    output logic [0:0]  m_tuser,
    // class_count register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int NODE_W    = $clog2(NODES);
    localparam int CUR_W     = (NODE_W > dtc_pkg::IDX_W) ? NODE_W : dtc_pkg::IDX_W;
    localparam int PADDR_W   = $clog2(NODES * CLASSES);
    localparam int CNT_W     = $clog2(CLASSES + 1);
    localparam int STEP_W    = $clog2(WALK_LIMIT + 1);
    localparam int RED_STEPS = dtc_pkg::red_shifts(NODES);
    localparam int NODE_BITS = $bits(dtc_pkg::node_t);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_EVAL     = 3'd2;
    localparam logic [2:0] ST_RED      = 3'd3;
    localparam logic [2:0] ST_PBASE    = 3'd4;
    localparam logic [2:0] ST_EMIT     = 3'd5;

    logic [2:0] state_reg, state_next;

    // captured command
    logic [dtc_pkg::CMD_W-1:0]       cmd_reg;
    logic [dtc_pkg::IDX_W-1:0]       nidx_reg;
    logic                            leaf_reg;
    logic [dtc_pkg::FIDX_W-1:0]      fidx_reg;
    logic [dtc_pkg::CIDX_W-1:0]      cidx_reg;
    logic signed [dtc_pkg::VAL_W-1:0] val_reg;
    logic [dtc_pkg::IDX_W-1:0]       lch_reg;
    logic [dtc_pkg::IDX_W-1:0]       rch_reg;

    logic [3:0]         class_count_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_eff;
    logic [CUR_W-1:0]   cur_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [3:0]         red_sh_reg;
    logic [dtc_pkg::CIDX_W-1:0] label_reg;
    logic [PADDR_W-1:0] base_reg;
    logic [CNT_W-1:0]   k_iss_reg;
    logic [CNT_W-1:0]   k_out_reg;
    logic               dv_reg;

    // output register
    logic                        out_valid_reg;
    logic [3:0]                  out_pred_reg;
    logic [3:0]                  out_rep_reg;
    logic [dtc_pkg::PROB_W-1:0]  out_prob_reg;
    logic                        out_last_reg;
    logic                        out_err_reg;

    // ram and store connections
    logic                  node_wr_en;
    logic                  node_rd_en;
    logic [NODE_W-1:0]     node_rd_addr;
    logic [NODE_W-1:0]     node_wr_addr;
    logic [NODE_BITS-1:0]  node_rd_raw;
    dtc_pkg::node_t        node_wr_data;
    dtc_pkg::node_t        node;
    logic                  prob_wr_en;
    logic [PADDR_W-1:0]    prob_wr_addr;
    logic                  prob_rd_en;
    logic [PADDR_W-1:0]    prob_rd_addr;
    logic [dtc_pkg::PROB_W-1:0] prob_rd_data;
    dtc_pkg::feat_wr_t     feat_wr;
    logic signed [dtc_pkg::VAL_W-1:0] feat_value;

    // walk and emit control
    logic                  s_accept;
    logic                  out_free;
    logic [CUR_W-1:0]      mul_a;
    logic [PADDR_W-1:0]    mul_p;
    logic                  go_left;
    logic [dtc_pkg::IDX_W-1:0] child;
    logic                  child_big;
    logic [31:0]           red_sub;
    logic [CUR_W-1:0]      red_cur;
    logic                  emit_load;
    logic                  emit_issue;
    logic                  emit_last;
    logic                  err_load;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign node      = dtc_pkg::node_t'(node_rd_raw);

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, out_prob_reg, out_rep_reg, out_pred_reg};
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_err_reg;

    // effective class count: zero means one, clamp to the table
    always_comb begin
        if (class_count_reg == 4'd0) begin
            cnt_eff = CNT_W'(1);
        end else if (32'(class_count_reg) > CLASSES) begin
            cnt_eff = CNT_W'(CLASSES);
        end else begin
            cnt_eff = CNT_W'(class_count_reg);
        end
    end

    // shared index multiplier: probability write address or leaf base address
    assign mul_a = (state_reg == ST_DISPATCH) ? CUR_W'(nidx_reg) : cur_reg;
    assign mul_p = PADDR_W'(32'(mul_a) * 32'(CLASSES));

    // branch decision on the node just read
    assign go_left   = (feat_value <= node.threshold);
    assign child     = go_left ? node.left : node.right;
    assign child_big = (32'(child) >= 32'(NODES));

    // one shifted compare-subtract step of the child reduction
    assign red_sub = 32'(NODES) << red_sh_reg;
    assign red_cur = (32'(cur_reg) >= red_sub) ? (cur_reg - CUR_W'(red_sub)) : cur_reg;

    // result stream: one probability read in flight ahead of the output register
    assign emit_load  = (state_reg == ST_EMIT) && dv_reg && out_free;
    assign emit_issue = (state_reg == ST_EMIT) && (k_iss_reg < cnt_reg)
                        && (!dv_reg || emit_load);
    assign emit_last  = ((k_out_reg + CNT_W'(1)) == cnt_reg);
    assign err_load   = (state_reg == ST_EVAL) && !node.leaf
                        && (32'(steps_reg) == WALK_LIMIT) && out_free;

    // table writes from the captured command, and the probability read of the result stream
    always_comb begin
        node_wr_en   = (state_reg == ST_DISPATCH) && (cmd_reg == dtc_pkg::CMD_WRITE_NODE)
                       && (32'(nidx_reg) < 32'(NODES));
        node_wr_addr = NODE_W'(CUR_W'(nidx_reg));
        node_wr_data = '{leaf: leaf_reg, feature: fidx_reg, threshold: val_reg,
                         left: lch_reg, right: rch_reg, label: cidx_reg};
        prob_wr_en   = (state_reg == ST_DISPATCH) && (cmd_reg == dtc_pkg::CMD_WRITE_PROB)
                       && (32'(nidx_reg) < 32'(NODES)) && (32'(cidx_reg) < CLASSES);
        prob_wr_addr = mul_p + PADDR_W'(cidx_reg);
        feat_wr.en    = (state_reg == ST_DISPATCH) && (cmd_reg == dtc_pkg::CMD_LOAD_FEATURE);
        feat_wr.idx   = fidx_reg;
        feat_wr.value = val_reg;
        prob_rd_en    = emit_issue;
        prob_rd_addr  = base_reg + PADDR_W'(k_iss_reg);
    end

    // node read requests of the walk
    always_comb begin
        node_rd_en   = 1'b0;
        node_rd_addr = '0;
        unique case (state_reg)
            ST_DISPATCH: begin
                node_rd_en = (cmd_reg == dtc_pkg::CMD_CLASSIFY);
            end
            ST_EVAL: begin
                if (!node.leaf && (32'(steps_reg) != WALK_LIMIT) && !child_big) begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = NODE_W'(CUR_W'(child));
                end
            end
            ST_RED: begin
                if (red_sh_reg == 4'd0) begin
                    node_rd_en   = 1'b1;
                    node_rd_addr = red_cur[NODE_W-1:0];
                end
            end
            default: begin
                node_rd_en = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = (cmd_reg == dtc_pkg::CMD_CLASSIFY) ? ST_EVAL : ST_IDLE;
            end
            ST_EVAL: begin
                if (node.leaf) begin
                    state_next = ST_PBASE;
                end else if (32'(steps_reg) == WALK_LIMIT) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (child_big) begin
                    state_next = ST_RED;
                end
            end
            ST_RED: begin
                if (red_sh_reg == 4'd0) begin
                    state_next = ST_EVAL;
                end
            end
            ST_PBASE: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_load && emit_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            class_count_reg <= 4'd3;
            out_valid_reg   <= 1'b0;
            dv_reg          <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                class_count_reg <= cfg_data;
            end
            if (emit_load || err_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_PBASE) begin
                dv_reg <= 1'b0;
            end else if (emit_issue) begin
                dv_reg <= 1'b1;
            end else if (emit_load) begin
                dv_reg <= 1'b0;
            end
        end
    end

    // command capture and walk datapath
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tuser;
            nidx_reg <= s_tdata[10:0];
            leaf_reg <= s_tdata[11];
            fidx_reg <= s_tdata[15:12];
            cidx_reg <= s_tdata[19:16];
            val_reg  <= s_tdata[51:20];
            lch_reg  <= s_tdata[62:52];
            rch_reg  <= s_tdata[73:63];
        end
        unique case (state_reg)
            ST_DISPATCH: begin
                cur_reg   <= '0;
                steps_reg <= '0;
                cnt_reg   <= cnt_eff;
            end
            ST_EVAL: begin
                if (node.leaf) begin
                    label_reg <= node.label;
                end else if (32'(steps_reg) != WALK_LIMIT) begin
                    steps_reg  <= steps_reg + STEP_W'(1);
                    cur_reg    <= CUR_W'(child);
                    red_sh_reg <= 4'(RED_STEPS - 1);
                end
            end
            ST_RED: begin
                cur_reg    <= red_cur;
                red_sh_reg <= red_sh_reg - 4'd1;
            end
            ST_PBASE: begin
                base_reg  <= mul_p;
                k_iss_reg <= '0;
                k_out_reg <= '0;
            end
            ST_EMIT: begin
                if (emit_issue) begin
                    k_iss_reg <= k_iss_reg + CNT_W'(1);
                end
                if (emit_load) begin
                    k_out_reg <= k_out_reg + CNT_W'(1);
                end
            end
            default: begin
                cur_reg <= cur_reg;
            end
        endcase
        // output payload
        if (emit_load) begin
            out_pred_reg <= label_reg;
            out_rep_reg  <= 4'(k_out_reg);
            out_prob_reg <= prob_rd_data;
            out_last_reg <= emit_last;
            out_err_reg  <= 1'b0;
        end else if (err_load) begin
            out_pred_reg <= '0;
            out_rep_reg  <= '0;
            out_prob_reg <= '0;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
        end
    end

    // node table
    dtc_ram #(
        .WIDTH (NODE_BITS),
        .DEPTH (NODES)
    ) u_node_ram (
        .aclk    (aclk),
        .wr_en   (node_wr_en),
        .wr_addr (node_wr_addr),
        .wr_data (NODE_BITS'(node_wr_data)),
        .rd_en   (node_rd_en),
        .rd_addr (node_rd_addr),
        .rd_data (node_rd_raw)
    );

    // class probability table
    dtc_ram #(
        .WIDTH (dtc_pkg::PROB_W),
        .DEPTH (NODES * CLASSES)
    ) u_prob_ram (
        .aclk    (aclk),
        .wr_en   (prob_wr_en),
        .wr_addr (prob_wr_addr),
        .wr_data (dtc_pkg::sat_prob(val_reg)),
        .rd_en   (prob_rd_en),
        .rd_addr (prob_rd_addr),
        .rd_data (prob_rd_data)
    );

    // feature values
    dtc_feat_store #(
        .FEATURES (FEATURES)
    ) u_feat_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (feat_wr),
        .rd_idx   (node.feature),
        .rd_value (feat_value)
    );

endmodule

// ===== tb/tb_top.sv =====
// testbench for the decision tree classifier: directed table, random trees, field-level result checks
`timescale 1ns / 100ps

module tb_top;
    import dtc_pkg::*;

    localparam int NODES        = 2048;
    localparam int CLASSES      = 10;
    localparam int FEATURES     = 10;
    localparam int WALK_LIMIT   = 10;
    localparam int RANDOM_ITEMS = 170;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;

    // one command transaction, fields as carried on s_tdata and s_tuser
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [IDX_W-1:0]        node;
        logic                    leaf;
        logic [FIDX_W-1:0]       feat;
        logic [CIDX_W-1:0]       cls;
        logic signed [VAL_W-1:0] val;
        logic [IDX_W-1:0]        lch;
        logic [IDX_W-1:0]        rch;
    } command_t;

    // one result transaction
    typedef struct packed {
        logic [3:0]        predicted;
        logic [3:0]        reported;
        logic [PROB_W-1:0] prob;
        logic              last;
        logic              depth_err;
    } score_t;

    // one row of the directed table
    typedef struct {
        bit         is_cfg;
        logic [3:0] cfg_value;
        command_t   c;
        bit         typed;
        score_t     want;
    } plan_row_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = '0;

    // shadow of the block's state
    node_t                   tree_nodes [NODES];
    bit                      node_known [NODES];
    logic [PROB_W-1:0]       class_probs [NODES*CLASSES];
    bit                      prob_known [NODES*CLASSES];
    logic signed [VAL_W-1:0] features [FEATURES];
    logic [3:0]              class_count_reg = 4'd3;

    score_t      expected_scores [$];
    int unsigned mismatches      = 0;
    int unsigned items_sent      = 0;
    int unsigned burst_left      = 0;
    int unsigned cycle_count     = 0;
    bit          hold_off_request = 1'b0;

    decision_tree_classify #(
        .NODES      (NODES),
        .CLASSES    (CLASSES),
        .FEATURES   (FEATURES),
        .WALK_LIMIT (WALK_LIMIT)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // reset values of the shadow state
    initial begin
        foreach (tree_nodes[i]) begin
            tree_nodes[i] = '0;
        end
        foreach (class_probs[i]) begin
            class_probs[i] = '0;
        end
        foreach (features[i]) begin
            features[i] = '0;
        end
    end

    function automatic int unsigned effective_count(logic [3:0] n);
        if (n == 0) begin
            return 1;
        end
        if (n > CLASSES) begin
            return CLASSES;
        end
        return n;
    endfunction

    // walk from the root; returns 1 on reaching a leaf, reports whether every node was written
    function automatic bit find_leaf(output int unsigned at, output bit known);
        node_t                   nd;
        int unsigned             steps;
        logic signed [VAL_W-1:0] f;
        logic [IDX_W-1:0]        next;
        at    = 0;
        known = node_known[0];
        nd    = tree_nodes[0];
        steps = 0;
        while (!nd.leaf && steps < WALK_LIMIT) begin
            f     = (nd.feature < FEATURES) ? features[nd.feature] : 32'sd0;
            next  = (f <= $signed(nd.threshold)) ? nd.left : nd.right;
            at    = next % NODES;
            known = known & node_known[at];
            nd    = tree_nodes[at];
            steps = steps + 1;
        end
        return nd.leaf;
    endfunction

    // a classify may only touch written nodes and written probabilities
    function automatic bit classify_is_safe();
        int unsigned at;
        bit          known;
        bit          reached;
        reached = find_leaf(at, known);
        if (!known) begin
            return 0;
        end
        if (reached) begin
            for (int unsigned k = 0; k < effective_count(class_count_reg); k++) begin
                if (!prob_known[at*CLASSES + k]) begin
                    return 0;
                end
            end
        end
        return 1;
    endfunction

    // update the shadow state for an accepted command and queue the results it causes
    function automatic void apply_command(command_t c, bit typed, score_t want);
        int unsigned at;
        int unsigned slot;
        bit          known;
        score_t      s;
        case (c.cmd)
            CMD_WRITE_NODE: begin
                if (c.node < NODES) begin
                    tree_nodes[c.node].leaf      = c.leaf;
                    tree_nodes[c.node].feature   = c.feat;
                    tree_nodes[c.node].threshold = c.val;
                    tree_nodes[c.node].left      = c.lch;
                    tree_nodes[c.node].right     = c.rch;
                    tree_nodes[c.node].label     = c.cls;
                    node_known[c.node]           = 1'b1;
                end
            end
            CMD_WRITE_PROB: begin
                if (c.cls < CLASSES) begin
                    slot = c.node * CLASSES + c.cls;
                    // clamp to 0..one
                    if (c.val < 0) begin
                        class_probs[slot] = '0;
                    end else if (c.val > 32'sd65536) begin
                        class_probs[slot] = 17'd65536;
                    end else begin
                        class_probs[slot] = c.val[PROB_W-1:0];
                    end
                    prob_known[slot] = 1'b1;
                end
            end
            CMD_LOAD_FEATURE: begin
                if (c.feat < FEATURES) begin
                    features[c.feat] = c.val;
                end
            end
            CMD_CLASSIFY: begin
                if (typed) begin
                    expected_scores.push_back(want);
                end else if (!find_leaf(at, known)) begin
                    s = '{predicted: 4'd0, reported: 4'd0, prob: '0, last: 1'b1,
                          depth_err: 1'b1};
                    expected_scores.push_back(s);
                end else begin
                    for (int unsigned k = 0; k < effective_count(class_count_reg); k++) begin
                        s.predicted = tree_nodes[at].label;
                        s.reported  = k;
                        s.prob      = class_probs[at*CLASSES + k];
                        s.last      = (k + 1 == effective_count(class_count_reg));
                        s.depth_err = 1'b0;
                        expected_scores.push_back(s);
                    end
                end
            end
        endcase
    endfunction

    function automatic command_t cmd_of(logic [1:0] op, logic [10:0] node, logic leaf,
                                        logic [3:0] feat, logic [3:0] cls, logic [31:0] val,
                                        logic [10:0] lch, logic [10:0] rch);
        command_t c;
        c = '{cmd: op, node: node, leaf: leaf, feat: feat, cls: cls, val: val,
              lch: lch, rch: rch};
        return c;
    endfunction

    function automatic plan_row_t cmd_row(command_t c, bit typed = 0, score_t want = '0);
        plan_row_t r;
        r = '{is_cfg: 0, cfg_value: 4'd0, c: c, typed: typed, want: want};
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [3:0] v);
        plan_row_t r;
        r = '{is_cfg: 1, cfg_value: v, c: '0, typed: 0, want: '0};
        return r;
    endfunction

    function automatic command_t random_command();
        command_t c;
        c = {$urandom, $urandom, $urandom};
        return c;
    endfunction

    // Q16.16 value mostly within a few units of zero so that splits go both ways
    function automatic logic [31:0] near_value();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom;
        end else begin
            v = (($urandom_range(0, 8) - 4) << 16) + ($urandom_range(0, 3) << 14);
        end
        return v;
    endfunction

    // offer one command, with bursts and random gaps on the sender side
    task automatic send_command(command_t c, bit typed = 0, score_t want = '0);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left = burst_left - 1;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= {6'b0, c.rch, c.lch, c.val, c.cls, c.feat, c.leaf, c.node};
        do @(posedge aclk); while (!s_tready);
        apply_command(c, typed, want);
        items_sent = items_sent + 1;
    endtask

    // register write, only once every expected result has come and the block settled
    task automatic write_class_count(logic [3:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        class_count_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // random tree rooted at node 0, with probabilities for every reported class
    task automatic grow_tree();
        int unsigned pending [$];
        int unsigned used [$];
        int unsigned idx;
        int unsigned kid;
        int unsigned n_internal;
        int unsigned eff;
        bit          clash;
        command_t    c;
        command_t    p;
        eff        = effective_count(class_count_reg);
        n_internal = $urandom_range(0, (eff > 5) ? 2 : 4);
        pending.push_back(0);
        used.push_back(0);
        while (pending.size() != 0) begin
            idx    = pending.pop_front();
            c      = random_command();
            c.cmd  = CMD_WRITE_NODE;
            c.node = idx;
            c.val  = near_value();
            if (n_internal != 0) begin
                n_internal = n_internal - 1;
                c.leaf = 1'b0;
                c.feat = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 15)
                                                     : $urandom_range(0, 9);
                for (int side = 0; side < 2; side++) begin
                    // now and then point back into the tree, which may end in a cycle
                    if ($urandom_range(0, 7) == 0) begin
                        kid = used[$urandom_range(0, used.size() - 1)];
                    end else begin
                        do begin
                            kid   = $urandom_range(1, NODES - 1);
                            clash = 0;
                            foreach (used[u]) begin
                                if (used[u] == kid) clash = 1;
                            end
                        end while (clash);
                        used.push_back(kid);
                        pending.push_back(kid);
                    end
                    if (side == 0) begin
                        c.lch = kid;
                    end else begin
                        c.rch = kid;
                    end
                end
            end else begin
                c.leaf = 1'b1;
            end
            send_command(c);
            if (c.leaf) begin
                for (int unsigned k = 0; k < eff; k++) begin
                    p      = random_command();
                    p.cmd  = CMD_WRITE_PROB;
                    p.node = idx;
                    p.cls  = k;
                    p.val  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 65536);
                    send_command(p);
                end
                if ($urandom_range(0, 3) == 0) begin
                    p      = random_command();
                    p.cmd  = CMD_WRITE_PROB;
                    p.node = idx;
                    p.cls  = $urandom_range(10, 15);
                    send_command(p);
                end
            end
        end
    endtask

    // new feature values, then a classify over the current tree
    task automatic classify_round();
        command_t c;
        repeat ($urandom_range(1, 3)) begin
            c      = random_command();
            c.cmd  = CMD_LOAD_FEATURE;
            c.feat = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
            c.val  = near_value();
            send_command(c);
        end
        if (classify_is_safe()) begin
            c     = random_command();
            c.cmd = CMD_CLASSIFY;
            send_command(c);
        end
    endtask

    // any command with random fields, as long as it reads nothing unwritten
    task automatic send_noise();
        command_t c;
        c = random_command();
        if (c.cmd != CMD_CLASSIFY || classify_is_safe()) begin
            send_command(c);
        end
    endtask

    // stimulus
    initial begin
        plan_row_t   plan [$];
        logic [3:0]  v;
        int unsigned phase;
        // leaf at the root, label beyond the class range, saturating probabilities
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_NODE, 0, 1, 0, 15, 0, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_PROB, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_PROB, 0, 0, 0, 1, 32'h8000_0000, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_PROB, 0, 0, 0, 2, 32'd65536, 0, 0)));
        // class beyond the table is dropped
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_PROB, 0, 0, 0, 15, 32'd5, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_CLASSIFY, 2047, 1, 15, 15, 32'hFFFF_FFFF, 2047, 2047)));
        // zero count reports one class
        plan.push_back(cfg_row(4'd0));
        plan.push_back(cmd_row(cmd_of(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0), 1,
                               '{4'd15, 4'd0, 17'd65536, 1'b1, 1'b0}));
        // split on a missing feature reads zero and loops on the root: walk limit hit
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_NODE, 0, 0, 10, 0, 0, 0, 2047)));
        plan.push_back(cmd_row(cmd_of(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0), 1,
                               '{4'd0, 4'd0, 17'd0, 1'b1, 1'b1}));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_NODE, 2047, 1, 15, 9, 32'h7FFF_FFFF,
                                      2047, 2047)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_PROB, 2047, 0, 0, 0, 32'd1, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_NODE, 0, 0, 15, 0, 32'hFFFF_FFFF, 0, 2047)));
        plan.push_back(cmd_row(cmd_of(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0), 1,
                               '{4'd9, 4'd0, 17'd1, 1'b1, 1'b0}));
        // most negative feature against most negative threshold goes left
        plan.push_back(cmd_row(cmd_of(CMD_LOAD_FEATURE, 0, 0, 9, 0, 32'h8000_0000, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_LOAD_FEATURE, 0, 0, 15, 0, 32'h7FFF_FFFF, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_NODE, 0, 0, 9, 0, 32'h8000_0000, 1, 2047)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_NODE, 1, 1, 0, 3, 0, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_WRITE_PROB, 1, 0, 0, 0, 32'h1234, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0), 1,
                               '{4'd3, 4'd0, 17'h1234, 1'b1, 1'b0}));
        // most positive feature goes right
        plan.push_back(cmd_row(cmd_of(CMD_LOAD_FEATURE, 0, 0, 9, 0, 32'h7FFF_FFFF, 0, 0)));
        plan.push_back(cmd_row(cmd_of(CMD_CLASSIFY, 0, 0, 0, 0, 0, 0, 0), 1,
                               '{4'd9, 4'd0, 17'd1, 1'b1, 1'b0}));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                write_class_count(plan[i].cfg_value);
            end else begin
                send_command(plan[i].c, plan[i].typed, plan[i].want);
            end
        end

        // random phases, each under its own class count
        phase = 0;
        while (items_sent < plan.size() + RANDOM_ITEMS) begin
            case (phase)
                0:       v = 4'd15;
                1:       v = 4'd10;
                2:       v = 4'd0;
                3:       v = 4'd1;
                default: v = $urandom_range(0, 15);
            endcase
            write_class_count(v);
            grow_tree();
            if (phase == 1) begin
                // receiver holds off while classifies pile up
                hold_off_request = 1'b1;
                repeat (6) classify_round();
            end else begin
                repeat ($urandom_range(2, 5)) classify_round();
            end
            repeat ($urandom_range(0, 4)) send_noise();
            phase = phase + 1;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("decision_tree_classify verification clean");
        end else begin
            $display("decision_tree_classify verification failed");
        end
        $finish;
    end

    // receiver stalls on a rotating pattern, with one long hold-off on request
    initial begin
        logic [7:0]  stall_pattern;
        int unsigned pattern_left;
        stall_pattern = 8'hFF;
        pattern_left  = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 8'hFF;
                    1:       stall_pattern = $urandom;
                    2:       stall_pattern = 8'h01;
                    default: stall_pattern = 8'hEE;
                endcase
                if (stall_pattern == 0) begin
                    stall_pattern = 8'h01;
                end
                pattern_left = $urandom_range(8, 64);
            end
            m_tready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            pattern_left  = pattern_left - 1;
        end
    end

    function automatic void check_field(string name, logic [16:0] want, logic [16:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches = mismatches + 1;
        end
    endfunction

    // compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        score_t got;
        score_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{predicted: m_tdata[3:0], reported: m_tdata[7:4], prob: m_tdata[24:8],
                    last: m_tlast, depth_err: m_tuser[0]};
            if (expected_scores.size() == 0) begin
                $display("%0t: result with nothing expected, got %p", $time, got);
                mismatches = mismatches + 1;
            end else begin
                want = expected_scores.pop_front();
                check_field("predicted_class", want.predicted, got.predicted);
                check_field("reported_class", want.reported, got.reported);
                check_field("probability", want.prob, got.prob);
                check_field("last", want.last, got.last);
                check_field("depth_error", want.depth_err, got.depth_err);
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("decision_tree_classify verification failed");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/dtc_pkg.sv
rtl/dtc_ram.sv
rtl/dtc_feat_store.sv
rtl/decision_tree_classify.sv
tb/tb_top.sv
